// File: hw/rtl/stable_priority_request_queue_top_defines.svh
// Assertion macros shared by the queue RTL.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef STABLE_PRIORITY_REQUEST_QUEUE_TOP_DEFINES_SVH
`define STABLE_PRIORITY_REQUEST_QUEUE_TOP_DEFINES_SVH

// A property that must hold at every rising clock edge outside reset.
`define SPRQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// A condition that must never be true outside reset.
`define SPRQ_ASSERT_NEVER(label, cond, msg) \
  `SPRQ_ASSERT(label, !(cond), msg)

`endif

// File: hw/rtl/sprq_pkg.sv
// Package for the stable priority request queue.
// Holds the request and response structs, status codes and the controller states.
package sprq_pkg;

  localparam int PRIO_BITS = 4;
  localparam int TAG_BITS  = 32;
  localparam int OCC_BITS  = 7;

  localparam logic MODE_ENQUEUE = 1'b0;
  localparam logic MODE_DEQUEUE = 1'b1;

  typedef enum logic [1:0] {
    STATUS_ENQUEUED = 2'd0,
    STATUS_DEQUEUED = 2'd1,
    STATUS_EMPTY    = 2'd2,
    STATUS_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    logic                 mode;
    logic [PRIO_BITS-1:0] priority_req;
    logic [TAG_BITS-1:0]  payload;
  } req_t;

  typedef struct packed {
    status_t              status;
    logic [TAG_BITS-1:0]  out_payload;
    logic [PRIO_BITS-1:0] out_priority;
    logic [OCC_BITS-1:0]  occupancy;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEQ,
    ST_SCAN,
    ST_SHIFT,
    ST_INSERT,
    ST_RESP
  } state_t;

endpackage

// File: hw/rtl/stable_priority_request_queue_top.sv
// Top level of the stable priority request queue: controller and entry memory.
// Depends on sprq_pkg and stable_priority_request_queue_top_defines.svh.
//
// Usage:
// A request enters on req_valid/req_stall/req_item and is either an enqueue or a
// dequeue. Every request produces exactly one response on rsp_valid/rsp_stall/
// rsp_item, in request order. The tail_priority register is written through
// cfg_valid/cfg_ready/cfg_data (always ready); the user must write it only while
// the queue is idle, which the block does not enforce. Entries live in a
// circular buffer in one synchronous memory (one read and one write port,
// registered read) addressed from a head pointer. From acceptance to the
// registered response, a dequeue makes one memory read of the head entry; an
// empty dequeue, a full enqueue and an enqueue at the tail priority or into
// an empty queue are answered directly from the idle state; a sorted enqueue
// walks the entries with the single read port once forward to find the
// insertion point and, if a larger priority is found, once backward to move
// the later entries up.
// The next request is accepted in the cycle after the response is made.
// If the receiver stalls, the finished response waits in a holding register
// and the queue accepts nothing until it has moved to the output register.
// Reset empties the queue, sets tail_priority to 1 and drops any response.
`include "stable_priority_request_queue_top_defines.svh"

module stable_priority_request_queue_top
  import sprq_pkg::*;
#(
  parameter int QUEUE_DEPTH  = 64,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  req_t                 req_item,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output rsp_t                 rsp_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [PRIO_BITS-1:0] cfg_data
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // Maps a logical position (0 is the front) to a memory slot.
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                         input logic [CW-1:0] idx);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(idx);
    if (s >= (CW+1)'(QUEUE_DEPTH)) begin
      s = s - (CW+1)'(QUEUE_DEPTH);
    end
    return AW'(s);
  endfunction

  // Controller registers.
  state_t               state, state_next;
  logic [AW-1:0]        head, head_next;
  logic [CW-1:0]        count, count_next;
  logic [CW-1:0]        cmp_idx, cmp_idx_next;
  logic [CW-1:0]        pos, pos_next;
  logic [CW-1:0]        sidx, sidx_next;
  logic [PRIO_BITS-1:0] tail_prio;
  req_t                 req_hold;
  rsp_t                 held;

  // Entry memory and its access signals.
  logic [PRIO_BITS-1:0]    prio_mem [QUEUE_DEPTH];
  logic [PAYLOAD_BITS-1:0] data_mem [QUEUE_DEPTH];
  logic [PRIO_BITS-1:0]    rd_prio;
  logic [PAYLOAD_BITS-1:0] rd_data;
  logic [AW-1:0]           raddr, waddr;
  logic                    mem_we;
  logic [PRIO_BITS-1:0]    wprio;
  logic [PAYLOAD_BITS-1:0] wdata;

  logic finish;
  logic slot_free;
  logic scan_hit;
  logic scan_last;
  rsp_t res;

  assign req_stall = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign slot_free = !rsp_valid || !rsp_stall;
  assign scan_hit  = (rd_prio > req_hold.priority_req);
  assign scan_last = (cmp_idx == count - CW'(1));

  // The tail priority register.
  always_ff @(posedge clk) begin
    if (rst) begin
      tail_prio <= PRIO_BITS'(1);
    end else if (cfg_valid && cfg_ready) begin
      tail_prio <= cfg_data;
    end
  end

  // Entry memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      prio_mem[waddr] <= wprio;
      data_mem[waddr] <= wdata;
    end
    rd_prio <= prio_mem[raddr];
    rd_data <= data_mem[raddr];
  end

  // Datapath and memory control.
  always_comb begin
    head_next    = head;
    count_next   = count;
    cmp_idx_next = cmp_idx;
    pos_next     = pos;
    sidx_next    = sidx;
    raddr        = head;
    waddr        = slot(head, count);
    mem_we       = 1'b0;
    wprio        = req_hold.priority_req;
    wdata        = PAYLOAD_BITS'(req_hold.payload);
    finish       = 1'b0;
    res          = '0;
    res.status   = STATUS_ENQUEUED;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          if (req_item.mode == MODE_DEQUEUE) begin
            if (count == '0) begin
              finish     = 1'b1;
              res.status = STATUS_EMPTY;
            end
          end else if (count == CW'(QUEUE_DEPTH)) begin
            finish     = 1'b1;
            res.status = STATUS_FULL;
          end else if (req_item.priority_req == tail_prio || count == '0) begin
            // Tail priority or empty queue: append at the back directly.
            mem_we     = 1'b1;
            wprio      = req_item.priority_req;
            wdata      = PAYLOAD_BITS'(req_item.payload);
            count_next = count + CW'(1);
            finish     = 1'b1;
          end else begin
            cmp_idx_next = '0;
          end
        end
      end
      ST_DEQ: begin
        res.status       = STATUS_DEQUEUED;
        res.out_payload  = TAG_BITS'(rd_data);
        res.out_priority = rd_prio;
        head_next        = slot(head, CW'(1));
        count_next       = count - CW'(1);
        finish           = 1'b1;
      end
      ST_SCAN: begin
        if (scan_hit) begin
          pos_next  = cmp_idx;
          sidx_next = count - CW'(1);
          raddr     = slot(head, count - CW'(1));
        end else if (scan_last) begin
          pos_next = count;
        end else begin
          raddr        = slot(head, cmp_idx + CW'(1));
          cmp_idx_next = cmp_idx + CW'(1);
        end
      end
      ST_SHIFT: begin
        mem_we = 1'b1;
        waddr  = slot(head, sidx + CW'(1));
        wprio  = rd_prio;
        wdata  = rd_data;
        if (sidx != pos) begin
          raddr     = slot(head, sidx - CW'(1));
          sidx_next = sidx - CW'(1);
        end
      end
      ST_INSERT: begin
        mem_we     = 1'b1;
        waddr      = slot(head, pos);
        count_next = count + CW'(1);
        finish     = 1'b1;
      end
      ST_RESP: begin
      end
      default: begin
      end
    endcase
    res.occupancy = OCC_BITS'(count_next);
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          if (req_item.mode == MODE_DEQUEUE) begin
            state_next = ST_DEQ;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_hit) begin
          state_next = ST_SHIFT;
        end else if (scan_last) begin
          state_next = ST_INSERT;
        end
      end
      ST_SHIFT: begin
        if (sidx == pos) begin
          state_next = ST_INSERT;
        end
      end
      ST_RESP: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
      end
    endcase
    if (finish) begin
      state_next = slot_free ? ST_IDLE : ST_RESP;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      head    <= '0;
      count   <= '0;
      cmp_idx <= '0;
      pos     <= '0;
      sidx    <= '0;
    end else begin
      state   <= state_next;
      head    <= head_next;
      count   <= count_next;
      cmp_idx <= cmp_idx_next;
      pos     <= pos_next;
      sidx    <= sidx_next;
    end
  end

  // Captured request and held response.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req_valid) begin
      req_hold <= req_item;
    end
    if (finish && !slot_free) begin
      held <= res;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((finish || state == ST_RESP) && slot_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish && slot_free) begin
      rsp_item <= res;
    end else if (state == ST_RESP && slot_free) begin
      rsp_item <= held;
    end
  end

  `SPRQ_ASSERT(a_count_bound, (count <= CW'(QUEUE_DEPTH)), "occupancy above depth")
  `SPRQ_ASSERT(a_count_step, ((count != $past(count)) |-> ((count == $past(count) + CW'(1)) || (count + CW'(1) == $past(count)))), "occupancy moved by more than one")
  `SPRQ_ASSERT_NEVER(a_shift_overlap, (state == ST_SHIFT && sidx != pos && waddr == raddr), "shift reads the slot it writes")
  `SPRQ_ASSERT(a_head_hold, ((state != ST_DEQ) |=> (head == $past(head))), "head moved without a dequeue")

endmodule

// File: tb/stable_priority_request_queue_top_tb.sv
// Self-checking testbench for stable_priority_request_queue_top, the sorted queue of request tags.
// It depends on sprq_pkg for the request and response types and on the RTL only.
// Predicted responses are kept in order and checked field by field as the block returns them.
module stable_priority_request_queue_top_tb;
  import sprq_pkg::*;

  // The block is built with its default depth, so a full queue holds 64 requests.
  localparam int DEPTH          = 64;
  // A sorted enqueue into a queue one short of full sets the settle time.
  localparam int SETTLE_CYCLES  = DEPTH + 16;
  // Cycles with no handshake of any kind before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 4000;
  // Length of the one long receiver hold-off that backs the queue up to its input.
  localparam int LONG_HOLD      = 300;
  // Only the first mismatches are printed; all of them are counted.
  localparam int PRINT_LIMIT    = 50;

  // The class mirrors the queue contents and the tail priority register. Each accepted
  // request is turned into the response the block owes for it, and the block's actual
  // responses are matched against those in order.
  class request_order_model;
    logic [PRIO_BITS-1:0] held_prio [DEPTH];
    logic [TAG_BITS-1:0]  held_tag  [DEPTH];
    int                   held_count;
    logic [PRIO_BITS-1:0] tail_prio;
    rsp_t                 due_responses [$];
    int                   mismatches;

    function new();
      held_count = 0;
      tail_prio  = 4'd1;
      mismatches = 0;
    endfunction

    // Works out the response for one accepted request and updates the mirrored queue.
    function void accept_request(req_t r);
      rsp_t res;
      int   pos;
      int   i;
      res = '0;
      if (r.mode == MODE_DEQUEUE) begin
        if (held_count == 0) begin
          res.status = STATUS_EMPTY;
        end else begin
          res.status       = STATUS_DEQUEUED;
          res.out_payload  = held_tag[0];
          res.out_priority = held_prio[0];
          for (i = 1; i < held_count; i++) begin
            held_tag[i-1]  = held_tag[i];
            held_prio[i-1] = held_prio[i];
          end
          held_count--;
        end
      end else if (held_count >= DEPTH) begin
        res.status = STATUS_FULL;
      end else begin
        // The tail priority goes straight to the back. Anything else lands just ahead of
        // the first entry with a larger priority, even if tail entries broke the order.
        pos = held_count;
        if (r.priority_req != tail_prio) begin
          for (i = 0; i < held_count; i++) begin
            if (held_prio[i] > r.priority_req) begin
              pos = i;
              break;
            end
          end
        end
        for (i = held_count; i > pos; i--) begin
          held_tag[i]  = held_tag[i-1];
          held_prio[i] = held_prio[i-1];
        end
        held_tag[pos]  = r.payload;
        held_prio[pos] = r.priority_req;
        held_count++;
        res.status = STATUS_ENQUEUED;
      end
      res.occupancy = held_count[OCC_BITS-1:0];
      due_responses.push_back(res);
    endfunction

    task report_mismatch(string what, logic [63:0] got_v, logic [63:0] want_v);
      mismatches++;
      if (mismatches <= PRINT_LIMIT) begin
        $display("mismatch on %s: got %0h, expected %0h", what, got_v, want_v);
      end
    endtask

    task check_response(rsp_t got);
      rsp_t want;
      if (due_responses.size() == 0) begin
        report_mismatch("response with nothing outstanding", 64'(got), 64'(0));
        return;
      end
      want = due_responses.pop_front();
      if (got.status !== want.status) begin
        report_mismatch("status", 64'(got.status), 64'(want.status));
      end
      if (got.out_payload !== want.out_payload) begin
        report_mismatch("out_payload", 64'(got.out_payload), 64'(want.out_payload));
      end
      if (got.out_priority !== want.out_priority) begin
        report_mismatch("out_priority", 64'(got.out_priority), 64'(want.out_priority));
      end
      if (got.occupancy !== want.occupancy) begin
        report_mismatch("occupancy", 64'(got.occupancy), 64'(want.occupancy));
      end
    endtask
  endclass

  logic                 clk;
  logic                 rst;
  logic                 req_valid;
  logic                 req_stall;
  req_t                 req_item;
  logic                 rsp_valid;
  logic                 rsp_stall;
  rsp_t                 rsp_item;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [PRIO_BITS-1:0] cfg_data;

  request_order_model board;

  // Idling switches for the two sides, changed per stretch of requests so that some
  // stretches run back to back and others are full of gaps.
  bit sender_idles;
  bit receiver_idles;
  // Raised by the sender to ask the receiver for the one long hold-off.
  bit hold_responses;
  int idle_cycles;

  stable_priority_request_queue_top u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_item  (req_item),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_item  (rsp_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int draw_gap(bit enabled);
    int k;
    if (!enabled) begin
      return 0;
    end
    k = $urandom_range(0, 99);
    if (k < 60) begin
      return 0;
    end else if (k < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic req_t make_request(logic mode, int prio, logic [TAG_BITS-1:0] tag);
    req_t r;
    r.mode         = mode;
    r.priority_req = prio[PRIO_BITS-1:0];
    r.payload      = tag;
    return r;
  endfunction

  // Random request with a given chance of being an enqueue. Priorities lean toward the
  // tail value and toward a few low values, so that ties and unsorted tails are common.
  function automatic req_t random_request(int enqueue_pct);
    int   k;
    int   prio;
    logic mode;
    mode = ($urandom_range(0, 99) < enqueue_pct) ? MODE_ENQUEUE : MODE_DEQUEUE;
    k    = $urandom_range(0, 9);
    if (k < 3) begin
      prio = int'(board.tail_prio);
    end else if (k < 6) begin
      prio = $urandom_range(0, 3);
    end else begin
      prio = $urandom_range(0, 15);
    end
    return make_request(mode, prio, $urandom);
  endfunction

  // Offers one request, holds it until the block takes it, then idles for a random gap.
  // Valid stays high into the next request when the gap is zero.
  task automatic send_request(req_t r);
    int gap;
    req_item  <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) begin
      @(posedge clk);
    end
    board.accept_request(r);
    gap = draw_gap(sender_idles);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering requests until every outstanding response has come back. Every request
  // produces a response, so the block is idle once the last one is back.
  task automatic wait_for_drain();
    req_valid <= 1'b0;
    while (board.due_responses.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // Tail priority is only written with the queue idle, after a drain.
  task automatic write_tail_priority(logic [PRIO_BITS-1:0] value);
    wait_for_drain();
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
    board.tail_prio = value;
  endtask

  // Receiver: random stalls when enabled, plus the single long hold-off on request.
  initial begin
    int n;
    bit hold_used;
    hold_used = 1'b0;
    rsp_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_responses && !hold_used) begin
        hold_used = 1'b1;
        rsp_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        rsp_stall <= 1'b0;
      end else if (receiver_idles && $urandom_range(0, 3) == 0) begin
        n = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 3) : $urandom_range(8, 40);
        rsp_stall <= 1'b1;
        repeat (n) @(posedge clk);
        rsp_stall <= 1'b0;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // Every response the block hands over is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      board.check_response(rsp_item);
    end
  end

  // The watchdog restarts on any handshake and ends the run if the block goes quiet.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int tail_values [7];
    int phase;
    int phase_items;
    int seg_len;
    int enqueue_pct;
    int i;

    board          = new();
    hold_responses = 1'b0;
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req_item  <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part, with the tail priority still at its reset value of 1. It starts with
    // a dequeue on the empty queue, then mixes sorted inserts, ties and tail appends so
    // that a later sorted insert has to land ahead of an out-of-order tail entry.
    send_request(make_request(MODE_DEQUEUE, 15, 32'hFFFF_FFFF));
    send_request(make_request(MODE_ENQUEUE, 15, 32'hFFFF_FFFF));
    send_request(make_request(MODE_ENQUEUE, 0, 32'h0000_0000));
    send_request(make_request(MODE_ENQUEUE, 1, 32'h0000_0001));
    send_request(make_request(MODE_ENQUEUE, 0, 32'h0000_0002));
    send_request(make_request(MODE_ENQUEUE, 2, 32'h0000_0003));
    send_request(make_request(MODE_ENQUEUE, 15, 32'hA5A5_A5A5));
    send_request(make_request(MODE_ENQUEUE, 7, 32'h5A5A_5A5A));
    send_request(make_request(MODE_ENQUEUE, 1, 32'h8000_0000));
    for (i = 0; i < 10; i++) begin
      send_request(make_request(MODE_DEQUEUE, 0, 32'h0000_0000));
    end
    send_request(make_request(MODE_DEQUEUE, 8, 32'h7FFF_FFFF));

    // Random part: phases under different tail priorities, the extremes among them.
    // Each phase is made of stretches that lean toward filling, draining or neither.
    tail_values = '{0, 15, 9, 1, 15, 0, 0};
    tail_values[6] = $urandom_range(0, 15);
    for (phase = 0; phase < 7; phase++) begin
      write_tail_priority(PRIO_BITS'(tail_values[phase]));
      phase_items = 0;

      if (phase == 1) begin
        // Fill the queue to the brim, knock on it while full, then empty it and
        // dequeue past the bottom.
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        while (board.held_count < DEPTH) begin
          send_request(random_request(100));
          phase_items++;
        end
        for (i = 0; i < 3; i++) begin
          send_request(random_request(100));
        end
        while (board.held_count > 0) begin
          send_request(random_request(0));
          phase_items++;
        end
        send_request(random_request(0));
        send_request(random_request(0));
        phase_items += 5;
      end

      if (phase == 3) begin
        // The receiver holds off for a long stretch while requests keep coming, so the
        // block backs up and stalls its input.
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        hold_responses = 1'b1;
        for (i = 0; i < 20; i++) begin
          send_request(random_request(70));
        end
        phase_items += 20;
      end

      while (phase_items < 120) begin
        seg_len        = $urandom_range(20, 70);
        sender_idles   = ($urandom_range(0, 3) != 0);
        receiver_idles = ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 2))
          0: begin
            enqueue_pct = 85;
          end
          1: begin
            enqueue_pct = 50;
          end
          default: begin
            enqueue_pct = 20;
          end
        endcase
        for (i = 0; i < seg_len; i++) begin
          send_request(random_request(enqueue_pct));
        end
        phase_items += seg_len;
      end
    end

    // All requests are in: wait for the last responses, then a little longer for stray ones.
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.due_responses.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
